// ===== design/hgt_pkg.sv =====
// Package for the heightfield grid triangulator.
// Holds field widths, default sizes, APB geometry, reset values, register indexes and record kind codes.
// No dependencies.
package hgt_pkg;

    // Fixed field widths of the record channel and the configuration registers.
    localparam int ID_BITS    = 24;
    localparam int COORD_BITS = 12;
    localparam int LEVEL_BITS = 16;
    localparam int COUNT_BITS = 13;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_MAX_COLUMNS = 4096;
    localparam int DEF_HEIGHT_BITS = 16;

    // APB port geometry.
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // Reset values of the configuration registers.
    localparam logic [LEVEL_BITS-1:0] NO_VALUE_RESET = 16'h8000;
    localparam logic [COUNT_BITS-1:0] ROWS_RESET     = 13'd4096;
    localparam logic [COUNT_BITS-1:0] COLUMNS_RESET  = 13'd4096;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_NO_VALUE_LEVEL = 2'd0,
        REG_ROWS_IN_USE    = 2'd1,
        REG_COLUMNS_IN_USE = 2'd2
    } reg_index_t;

    // Record kinds on the output channel.
    localparam logic REC_VERTEX   = 1'b0;
    localparam logic REC_TRIANGLE = 1'b1;

endpackage

// ===== design/heightfield_grid_triangulator.sv =====
// Heightfield grid triangulator top level: vertex numbering, cell closing and
// record serialization. Depends on hgt_pkg.
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid / sample_stall height
//   record    out        record_valid / record_stall record_kind .. last_of_run
//   apb       in/out     psel penable pwrite pready  paddr pwdata prdata
//
// Each sample is decided in the cycle it is accepted; its records (none to three)
// then leave the output register one per cycle while the record channel is not
// stalled, and the next sample is accepted once no pending record would remain.
// The line store of vertex ids is read one row ahead and written once per sample.
// Reset clears counters, corner ids and the pending records; the line store
// is not cleared. A stalled record channel holds the output register and
// stalls the sample channel once the pending records cannot advance.
module heightfield_grid_triangulator
    import hgt_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [HEIGHT_BITS-1:0]  height,

    output logic                           record_valid,
    input  logic                           record_stall,
    output logic                           record_kind,
    output logic [COORD_BITS-1:0]          column,
    output logic [COORD_BITS-1:0]          row,
    output logic signed [HEIGHT_BITS-1:0]  vertex_height,
    output logic [ID_BITS-1:0]             vertex_index,
    output logic [ID_BITS-1:0]             corner_a,
    output logic [ID_BITS-1:0]             corner_b,
    output logic [ID_BITS-1:0]             corner_c,
    output logic                           last_of_run,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_ADDR_BITS-1:0]       paddr,
    input  logic [APB_DATA_BITS-1:0]       pwdata,
    output logic [APB_DATA_BITS-1:0]       prdata,
    output logic                           pready
);

    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int RCMP_W = (RW + 1 > COUNT_BITS) ? RW + 1 : COUNT_BITS;
    localparam int CCMP_W = (CW + 1 > COUNT_BITS) ? CW + 1 : COUNT_BITS;
    localparam int HCMP_W = (HEIGHT_BITS > LEVEL_BITS) ? HEIGHT_BITS : LEVEL_BITS;

    // Configuration registers.
    logic [LEVEL_BITS-1:0] cfg_level_reg;
    logic [COUNT_BITS-1:0] cfg_rows_reg;
    logic [COUNT_BITS-1:0] cfg_cols_reg;
    reg_index_t            apb_index;
    logic                  apb_write;

    // Grid walk state.
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [ID_BITS-1:0] vcnt_reg, vcnt_next;
    logic [ID_BITS:0]   left_reg, left_next;
    logic [ID_BITS:0]   diag_reg, diag_next;

    // Line store with registered read and a bypass for same-row rewrites.
    logic [ID_BITS:0]   line_mem [MAX_ROWS];
    logic [ID_BITS:0]   line_rd_reg;
    logic               byp_hit_reg;
    logic [ID_BITS:0]   byp_data_reg;

    // Pending records of the sample in flight.
    logic [2:0]                    pend_reg, pend_next;
    logic [COORD_BITS-1:0]         jcol_reg, jrow_reg;
    logic signed [HEIGHT_BITS-1:0] jh_reg;
    logic [ID_BITS-1:0]            jidx_reg;
    logic [ID_BITS-1:0]            t0a_reg, t0b_reg, t0c_reg;
    logic [ID_BITS-1:0]            t1a_reg, t1b_reg, t1c_reg;

    // Output register.
    logic                          rv_reg;
    logic                          rkind_reg;
    logic [COORD_BITS-1:0]         rcol_reg, rrow_reg;
    logic signed [HEIGHT_BITS-1:0] rh_reg;
    logic [ID_BITS-1:0]            ridx_reg, ra_reg, rb_reg, rc_reg;
    logic                          rlast_reg;

    // Per-sample decision logic.
    logic                      accept;
    logic                      out_free;
    logic                      load_out;
    logic [2:0]                pick;
    logic [2:0]                pend_left;
    logic signed [HCMP_W-1:0]  h_ext, lvl_ext;
    logic                      is_vtx;
    logic [ID_BITS:0]          cur;
    logic [ID_BITS:0]          above;
    logic [RCMP_W-1:0]         rows_lim, row_plus1;
    logic [CCMP_W-1:0]         cols_lim, col_plus1;
    logic                      row_wrap, col_wrap;
    logic                      in_cell;
    logic                      va, vb, vd, ve;
    logic [1:0]                ntri;
    logic [ID_BITS-1:0]        n0a, n0b, n0c;

    // APB register access; writes land on the access phase.
    assign pready    = 1'b1;
    assign apb_index = reg_index_t'(paddr[3:2]);
    assign apb_write = psel && penable && pwrite;

    always_comb
    begin
        case (apb_index)
            REG_NO_VALUE_LEVEL: prdata = APB_DATA_BITS'(cfg_level_reg);
            REG_ROWS_IN_USE:    prdata = APB_DATA_BITS'(cfg_rows_reg);
            REG_COLUMNS_IN_USE: prdata = APB_DATA_BITS'(cfg_cols_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_level_reg <= NO_VALUE_RESET;
            cfg_rows_reg  <= ROWS_RESET;
            cfg_cols_reg  <= COLUMNS_RESET;
        end
        else if (apb_write)
        begin
            case (apb_index)
                REG_NO_VALUE_LEVEL: cfg_level_reg <= pwdata[LEVEL_BITS-1:0];
                REG_ROWS_IN_USE:    cfg_rows_reg  <= pwdata[COUNT_BITS-1:0];
                REG_COLUMNS_IN_USE: cfg_cols_reg  <= pwdata[COUNT_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Record serialization: the lowest pending bit goes out next.
    assign out_free  = !rv_reg || !record_stall;
    assign load_out  = out_free && (pend_reg != 3'b000);
    assign pick      = pend_reg & (~pend_reg + 3'b001);
    assign pend_left = pend_reg & ~pick;

    // The sample waits only while pending records remain after this cycle.
    assign sample_stall = (pend_reg != 3'b000) && !(load_out && pend_left == 3'b000);
    assign accept       = sample_valid && !sample_stall;

    // Vertex test and the id of the current corner.
    assign h_ext   = HCMP_W'(height);
    assign lvl_ext = HCMP_W'($signed(cfg_level_reg));
    assign is_vtx  = h_ext > lvl_ext;
    assign cur     = is_vtx ? {1'b1, vcnt_reg} : '0;
    assign above   = (col_reg != '0) ? (byp_hit_reg ? byp_data_reg : line_rd_reg) : '0;

    // Effective grid size: zero counts as one, large counts saturate.
    always_comb
    begin
        if (cfg_rows_reg == '0)
            rows_lim = RCMP_W'(1);
        else if (RCMP_W'(cfg_rows_reg) > RCMP_W'(MAX_ROWS))
            rows_lim = RCMP_W'(MAX_ROWS);
        else
            rows_lim = RCMP_W'(cfg_rows_reg);

        if (cfg_cols_reg == '0)
            cols_lim = CCMP_W'(1);
        else if (CCMP_W'(cfg_cols_reg) > CCMP_W'(MAX_COLUMNS))
            cols_lim = CCMP_W'(MAX_COLUMNS);
        else
            cols_lim = CCMP_W'(cfg_cols_reg);
    end

    assign row_plus1 = RCMP_W'(row_reg) + RCMP_W'(1);
    assign col_plus1 = CCMP_W'(col_reg) + CCMP_W'(1);
    assign row_wrap  = row_plus1 >= rows_lim;
    assign col_wrap  = col_plus1 >= cols_lim;

    // Cell corners: v00 diagonal, v01 above, v10 left, v11 current.
    assign in_cell = (col_reg != '0) && (row_reg != '0);
    assign va      = diag_reg[ID_BITS];
    assign vb      = above[ID_BITS];
    assign vd      = left_reg[ID_BITS];
    assign ve      = cur[ID_BITS];

    // Triangle choice in fixed priority order.
    always_comb
    begin
        ntri = 2'd0;
        n0a  = diag_reg[ID_BITS-1:0];
        n0b  = left_reg[ID_BITS-1:0];
        n0c  = above[ID_BITS-1:0];
        if (in_cell)
        begin
            if (va && vb && vd && ve)
            begin
                ntri = 2'd2;
            end
            else if (va && vd && ve)
            begin
                ntri = 2'd1;
                n0c  = cur[ID_BITS-1:0];
            end
            else if (va && ve && vb)
            begin
                ntri = 2'd1;
                n0b  = cur[ID_BITS-1:0];
            end
            else if (va && vd && vb)
            begin
                ntri = 2'd1;
            end
            else if (vb && vd && ve)
            begin
                ntri = 2'd1;
                n0a  = above[ID_BITS-1:0];
                n0c  = cur[ID_BITS-1:0];
            end
        end
    end

    // Next state of the grid walk.
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        vcnt_next = vcnt_reg;
        left_next = left_reg;
        diag_next = diag_reg;
        if (accept)
        begin
            vcnt_next = is_vtx ? vcnt_reg + ID_BITS'(1) : vcnt_reg;
            left_next = cur;
            diag_next = above;
            if (row_wrap)
            begin
                row_next  = '0;
                left_next = '0;
                diag_next = '0;
                if (col_wrap)
                begin
                    col_next  = '0;
                    vcnt_next = '0;
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            else
            begin
                row_next = row_reg + RW'(1);
            end
        end
    end

    // Next pending mask: vertex, first triangle, second triangle.
    always_comb
    begin
        pend_next = load_out ? pend_left : pend_reg;
        if (accept)
            pend_next = {ntri == 2'd2, ntri != 2'd0, is_vtx};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            vcnt_reg    <= '0;
            left_reg    <= '0;
            diag_reg    <= '0;
            pend_reg    <= 3'b000;
            rv_reg      <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            vcnt_reg    <= vcnt_next;
            left_reg    <= left_next;
            diag_reg    <= diag_next;
            pend_reg    <= pend_next;
            byp_hit_reg <= accept && (row_next == row_reg);
            if (out_free)
                rv_reg <= load_out;
        end
    end

    // Line store: one write per sample, read of the row that comes next.
    always_ff @(posedge clk)
    begin
        if (accept)
            line_mem[row_reg] <= cur;
        line_rd_reg <= line_mem[row_next];
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= cur;
    end

    // Payload of the sample's pending records.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            jcol_reg <= COORD_BITS'(col_reg);
            jrow_reg <= COORD_BITS'(row_reg);
            jh_reg   <= height;
            jidx_reg <= vcnt_reg;
            t0a_reg  <= n0a;
            t0b_reg  <= n0b;
            t0c_reg  <= n0c;
            t1a_reg  <= above[ID_BITS-1:0];
            t1b_reg  <= left_reg[ID_BITS-1:0];
            t1c_reg  <= cur[ID_BITS-1:0];
        end
    end

    // Output register loads the selected record.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rlast_reg <= (pend_left == 3'b000);
            if (pick[0])
            begin
                rkind_reg <= REC_VERTEX;
                rcol_reg  <= jcol_reg;
                rrow_reg  <= jrow_reg;
                rh_reg    <= jh_reg;
                ridx_reg  <= jidx_reg;
                ra_reg    <= '0;
                rb_reg    <= '0;
                rc_reg    <= '0;
            end
            else
            begin
                rkind_reg <= REC_TRIANGLE;
                rcol_reg  <= '0;
                rrow_reg  <= '0;
                rh_reg    <= '0;
                ridx_reg  <= '0;
                ra_reg    <= pick[1] ? t0a_reg : t1a_reg;
                rb_reg    <= pick[1] ? t0b_reg : t1b_reg;
                rc_reg    <= pick[1] ? t0c_reg : t1c_reg;
            end
        end
    end

    assign record_valid  = rv_reg;
    assign record_kind   = rkind_reg;
    assign column        = rcol_reg;
    assign row           = rrow_reg;
    assign vertex_height = rh_reg;
    assign vertex_index  = ridx_reg;
    assign corner_a      = ra_reg;
    assign corner_b      = rb_reg;
    assign corner_c      = rc_reg;
    assign last_of_run   = rlast_reg;

endmodule
